@@ src/shacrypt_pkg.sv @@
// Shared types, constants and functions of the SHA-256 crypt engine.
package shacrypt_pkg;

  localparam int MAX_PASSWORD_BYTES = 64;
  localparam int MAX_SALT_BYTES     = 16;

  localparam int PW_AW   = (MAX_PASSWORD_BYTES > 1) ? $clog2(MAX_PASSWORD_BYTES) : 1;
  localparam int SALT_AW = (MAX_SALT_BYTES > 1) ? $clog2(MAX_SALT_BYTES) : 1;
  localparam int PLEN_W  = $clog2(MAX_PASSWORD_BYTES + 1);
  localparam int SLEN_W  = $clog2(MAX_SALT_BYTES + 1);
  localparam int SEG_W   = (PLEN_W > 7) ? PLEN_W : 7;
  localparam int REP_W   = (PLEN_W > 9) ? PLEN_W : 9;
  localparam int ROUND_W = 30;

  localparam logic [ROUND_W-1:0] ROUNDS_LOW   = 30'd1000;
  localparam logic [ROUND_W-1:0] ROUNDS_HIGH  = 30'd999999999;
  localparam logic [ROUND_W-1:0] ROUNDS_RESET = 30'd5000;

  localparam logic [5:0] LAST_CHAR_IDX = 6'd42;
  localparam logic [5:0] BLOCK_LAST    = 6'd63;
  localparam logic [REP_W-1:0] SALT_BASE_REPS = REP_W'(16);
  localparam logic [SEG_W-1:0] HASH_BYTES     = SEG_W'(32);

  localparam logic [255:0] H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [1:0] {
    KIND_PW      = 2'd0,
    KIND_SALT    = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    SRC_PW, SRC_SALT, SRC_B, SRC_PSEQ, SRC_SSEQ, SRC_RUN, SRC_PAD
  } src_t;

  typedef enum logic [2:0] {
    DST_B, DST_A, DST_RUN, DST_P, DST_S
  } dst_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PLAN, ST_READ, ST_SHIFT, ST_WAIT, ST_EMIT
  } state_t;

  typedef enum logic [4:0] {
    STEP_B_PW1, STEP_B_SALT, STEP_B_PW2, STEP_B_FIN,
    STEP_A_PW, STEP_A_SALT, STEP_A_BLK, STEP_A_BIT, STEP_A_FIN,
    STEP_DP_PW, STEP_DP_FIN, STEP_DS_SALT, STEP_DS_FIN,
    STEP_R_FIRST, STEP_R_SALT, STEP_R_SEVEN, STEP_R_LAST, STEP_R_FIN,
    STEP_OUT
  } step_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
    logic       input_truncated;
  } out_word_t;

  typedef struct packed {
    logic             load;
    logic             msg_start;
    logic             shift;
    src_t             src;
    logic [SEG_W-1:0] idx;
    logic             pad_begin;
    logic             store;
    dst_t             dst;
    logic             round_clear;
    logic             round_inc;
    logic             emit;
    logic [5:0]       emit_idx;
    logic             clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic              core_done;
    logic              blk_last;
    logic [6:0]        pad_len;
    logic [7:0]        a0;
    logic [PLEN_W-1:0] plen;
    logic [SLEN_W-1:0] slen;
    logic              rounds_done;
    logic              r_odd;
    logic              r3_zero;
    logic              r7_zero;
  } ctrl_stat_t;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] round_k(logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Byte k of a digest, byte 0 in the top bits.
  function automatic logic [7:0] get_byte(logic [255:0] d, logic [4:0] k);
    return d[{~k, 3'b000} +: 8];
  endfunction

  // Digest byte positions of the three bytes that form one output group.
  function automatic logic [14:0] emit_ix(logic [3:0] g);
    logic [14:0] r;
    case (g)
      4'd0:    r = {5'd0,  5'd10, 5'd20};
      4'd1:    r = {5'd21, 5'd1,  5'd11};
      4'd2:    r = {5'd12, 5'd22, 5'd2};
      4'd3:    r = {5'd3,  5'd13, 5'd23};
      4'd4:    r = {5'd24, 5'd4,  5'd14};
      4'd5:    r = {5'd15, 5'd25, 5'd5};
      4'd6:    r = {5'd6,  5'd16, 5'd26};
      4'd7:    r = {5'd27, 5'd7,  5'd17};
      4'd8:    r = {5'd18, 5'd28, 5'd8};
      4'd9:    r = {5'd9,  5'd19, 5'd29};
      default: r = 15'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] b64_char(logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd12) begin
      c = 8'h2e + {2'b00, v};
    end else if (v < 6'd38) begin
      c = 8'h35 + {2'b00, v};
    end else begin
      c = 8'h3b + {2'b00, v};
    end
    return c;
  endfunction

  function automatic logic [7:0] emit_char(logic [255:0] d, logic [5:0] k);
    logic [14:0] ix;
    logic [23:0] w;
    logic [1:0]  c;
    logic [5:0]  s;
    if (k < 6'd40) begin
      ix = emit_ix(k[5:2]);
      w  = {get_byte(d, ix[14:10]), get_byte(d, ix[9:5]), get_byte(d, ix[4:0])};
      c  = k[1:0];
    end else begin
      ix = 15'd0;
      w  = {8'd0, get_byte(d, 5'd31), get_byte(d, 5'd30)};
      c  = 2'(k - 6'd40);
    end
    case (c)
      2'd0:    s = w[5:0];
      2'd1:    s = w[11:6];
      2'd2:    s = w[17:12];
      default: s = w[23:18];
    endcase
    return b64_char(s);
  endfunction

endpackage

@@ src/shacrypt_ram.sv @@
// Generic single-port RAM with registered read.
module shacrypt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ src/shacrypt_core.sv @@
// Iterative SHA-256 compression unit: one round per cycle plus a final add.
module shacrypt_core
  import shacrypt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         init,
  input  logic         go,
  input  logic [511:0] block,
  output logic [255:0] chain,
  output logic         done
);

  logic [31:0] w [16];
  logic [31:0] v [8];
  logic [5:0]  rnd;
  logic        running;
  logic        fin;
  logic [31:0] t1, t2, w_new;

  always_comb begin
    t1 = v[7] + big_s1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(rnd) + w[0];
    t2 = big_s0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    w_new = small_s1(w[14]) + w[9] + small_s0(w[1]) + w[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fin     <= 1'b0;
      done    <= 1'b0;
      rnd     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        rnd     <= '0;
      end else if (running) begin
        rnd <= rnd + 6'd1;
        if (rnd == 6'd63) begin
          running <= 1'b0;
          fin     <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (init) begin
      chain <= H_INIT;
    end else if (fin) begin
      for (int i = 0; i < 8; i++) begin
        chain[32*(7-i) +: 32] <= chain[32*(7-i) +: 32] + v[i];
      end
    end
    if (go) begin
      for (int i = 0; i < 16; i++) begin
        w[i] <= block[32*(15-i) +: 32];
      end
      for (int i = 0; i < 8; i++) begin
        v[i] <= chain[32*(7-i) +: 32];
      end
    end else if (running) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_new;
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule

@@ src/shacrypt_dp.sv @@
// Datapath: byte stores, digests, message block assembly, hash unit and output.
module shacrypt_dp
  import shacrypt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  in_word_t           item,
  input  ctrl_cmd_t          cmd,
  input  logic [ROUND_W-1:0] round_count,
  output ctrl_stat_t         stat,
  output logic               strobe,
  output out_word_t          result
);

  logic [PLEN_W-1:0]  plen;
  logic [SLEN_W-1:0]  slen;
  logic               trunc;
  logic               pw_we, salt_we, pw_full, salt_full;
  logic [PW_AW-1:0]   pw_addr;
  logic [SALT_AW-1:0] salt_addr;
  logic [7:0]         pw_rdata, salt_rdata;
  logic [255:0]       dig_b, dig_p, dig_s, run, chain;
  logic [7:0]         a0;
  logic [511:0]       block;
  logic [31:0]        cnt;
  logic [63:0]        len_bits;
  logic [6:0]         pad_len, pad_len_q;
  logic               pad_len_byte;
  logic               core_go, core_done;
  logic [ROUND_W-1:0] rnd;
  logic [1:0]         r3;
  logic [2:0]         r7;
  logic [7:0]         feed_byte;

  assign pw_full   = (plen == PLEN_W'(MAX_PASSWORD_BYTES));
  assign salt_full = (slen == SLEN_W'(MAX_SALT_BYTES));
  assign pw_we     = cmd.load && (item.kind == KIND_PW) && !pw_full;
  assign salt_we   = cmd.load && (item.kind == KIND_SALT) && !salt_full;
  assign pw_addr   = cmd.load ? plen[PW_AW-1:0] : cmd.idx[PW_AW-1:0];
  assign salt_addr = cmd.load ? slen[SALT_AW-1:0] : cmd.idx[SALT_AW-1:0];

  shacrypt_ram #(.WIDTH(8), .DEPTH(MAX_PASSWORD_BYTES)) u_pw_ram (
    .clk   (clk),
    .we    (pw_we),
    .addr  (pw_addr),
    .wdata (item.data_byte),
    .rdata (pw_rdata)
  );

  shacrypt_ram #(.WIDTH(8), .DEPTH(MAX_SALT_BYTES)) u_salt_ram (
    .clk   (clk),
    .we    (salt_we),
    .addr  (salt_addr),
    .wdata (item.data_byte),
    .rdata (salt_rdata)
  );

  shacrypt_core u_core (
    .clk   (clk),
    .rst   (rst),
    .init  (cmd.msg_start | cmd.store),
    .go    (core_go),
    .block (block),
    .chain (chain),
    .done  (core_done)
  );

  // Padding is 0x80, zeros up to byte 56 of a block, then the bit length.
  assign pad_len      = {1'b0, 6'(6'd55 - cnt[5:0])} + 7'd9;
  assign pad_len_byte = (cmd.idx >= (SEG_W'(pad_len_q) - SEG_W'(8)));

  always_comb begin
    case (cmd.src)
      SRC_PW:   feed_byte = pw_rdata;
      SRC_SALT: feed_byte = salt_rdata;
      SRC_B:    feed_byte = get_byte(dig_b, cmd.idx[4:0]);
      SRC_PSEQ: feed_byte = get_byte(dig_p, cmd.idx[4:0]);
      SRC_SSEQ: feed_byte = get_byte(dig_s, cmd.idx[4:0]);
      SRC_RUN:  feed_byte = get_byte(run, cmd.idx[4:0]);
      SRC_PAD: begin
        if (cmd.idx == '0) begin
          feed_byte = 8'h80;
        end else if (pad_len_byte) begin
          feed_byte = len_bits[63:56];
        end else begin
          feed_byte = 8'h00;
        end
      end
      default:  feed_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen    <= '0;
      slen    <= '0;
      trunc   <= 1'b0;
      cnt     <= '0;
      core_go <= 1'b0;
      rnd     <= '0;
      r3      <= '0;
      r7      <= '0;
      strobe  <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (item.kind == KIND_PW) begin
          if (pw_full) begin
            trunc <= 1'b1;
          end else begin
            plen <= plen + PLEN_W'(1);
          end
        end else if (item.kind == KIND_SALT) begin
          if (salt_full) begin
            trunc <= 1'b1;
          end else begin
            slen <= slen + SLEN_W'(1);
          end
        end
      end
      if (cmd.clear) begin
        plen  <= '0;
        slen  <= '0;
        trunc <= 1'b0;
      end
      if (cmd.msg_start || cmd.store) begin
        cnt <= '0;
      end else if (cmd.shift) begin
        cnt <= cnt + 32'd1;
      end
      core_go <= cmd.shift && (cnt[5:0] == BLOCK_LAST);
      if (cmd.round_clear) begin
        rnd <= '0;
        r3  <= '0;
        r7  <= '0;
      end else if (cmd.round_inc) begin
        rnd <= rnd + ROUND_W'(1);
        r3  <= (r3 == 2'd2) ? 2'd0 : r3 + 2'd1;
        r7  <= (r7 == 3'd6) ? 3'd0 : r7 + 3'd1;
      end
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      block <= {block[503:0], feed_byte};
    end
    if (cmd.pad_begin) begin
      len_bits  <= {29'd0, cnt, 3'b000};
      pad_len_q <= pad_len;
    end else if (cmd.shift && (cmd.src == SRC_PAD) && (cmd.idx != '0) && pad_len_byte) begin
      len_bits <= {len_bits[55:0], 8'h00};
    end
    if (cmd.store) begin
      case (cmd.dst)
        DST_B: dig_b <= chain;
        DST_A: begin
          run <= chain;
          a0  <= chain[255:248];
        end
        DST_RUN: run <= chain;
        DST_P:   dig_p <= chain;
        DST_S:   dig_s <= chain;
        default: run <= chain;
      endcase
    end
    if (cmd.emit) begin
      result.out_char        <= emit_char(run, cmd.emit_idx);
      result.last_char       <= (cmd.emit_idx == LAST_CHAR_IDX);
      result.input_truncated <= trunc;
    end
  end

  always_comb begin
    stat.core_done   = core_done;
    stat.blk_last    = (cnt[5:0] == BLOCK_LAST);
    stat.pad_len     = pad_len;
    stat.a0          = a0;
    stat.plen        = plen;
    stat.slen        = slen;
    stat.rounds_done = (rnd == round_count);
    stat.r_odd       = rnd[0];
    stat.r3_zero     = (r3 == 2'd0);
    stat.r7_zero     = (r7 == 3'd0);
  end

endmodule

@@ src/shacrypt_ctrl.sv @@
// Controller: walks the scheme's message segments and sequences the datapath.
module shacrypt_ctrl
  import shacrypt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  in_word_t   item,
  input  ctrl_stat_t stat,
  output logic       busy,
  output ctrl_cmd_t  cmd
);

  state_t           state, state_next;
  step_t            step, step_next;
  src_t             seg_src, plan_src;
  dst_t             seg_dst, plan_dst;
  logic [SEG_W-1:0] seg_len, seg_idx, plan_len, a_rem, a_rem_next;
  logic [PLEN_W-1:0] a_bits, a_bits_next;
  logic [REP_W-1:0] rep, rep_next;
  logic [5:0]       emit_idx;
  logic             plan_fin, plan_rclear, plan_rinc;
  logic             accept, seg_done;
  logic [SEG_W-1:0] plen_s, slen_s;

  assign accept   = start && (state == ST_IDLE);
  assign busy     = (state != ST_IDLE);
  assign seg_done = (seg_idx == seg_len);
  assign plen_s   = SEG_W'(stat.plen);
  assign slen_s   = SEG_W'(stat.slen);

  // One segment of the current message per visit to the planning state.
  always_comb begin
    step_next   = step;
    plan_src    = SRC_PW;
    plan_dst    = DST_B;
    plan_len    = '0;
    plan_fin    = 1'b0;
    plan_rclear = 1'b0;
    plan_rinc   = 1'b0;
    a_rem_next  = a_rem;
    a_bits_next = a_bits;
    rep_next    = rep;
    case (step)
      STEP_B_PW1: begin
        plan_len  = plen_s;
        step_next = STEP_B_SALT;
      end
      STEP_B_SALT: begin
        plan_src  = SRC_SALT;
        plan_len  = slen_s;
        step_next = STEP_B_PW2;
      end
      STEP_B_PW2: begin
        plan_len  = plen_s;
        step_next = STEP_B_FIN;
      end
      STEP_B_FIN: begin
        plan_src  = SRC_PAD;
        plan_len  = SEG_W'(stat.pad_len);
        plan_fin  = 1'b1;
        plan_dst  = DST_B;
        step_next = STEP_A_PW;
      end
      STEP_A_PW: begin
        plan_len   = plen_s;
        a_rem_next = plen_s;
        step_next  = STEP_A_SALT;
      end
      STEP_A_SALT: begin
        plan_src  = SRC_SALT;
        plan_len  = slen_s;
        step_next = STEP_A_BLK;
      end
      STEP_A_BLK: begin
        plan_src = SRC_B;
        if (a_rem > HASH_BYTES) begin
          plan_len   = HASH_BYTES;
          a_rem_next = a_rem - HASH_BYTES;
        end else begin
          plan_len    = a_rem;
          a_bits_next = stat.plen;
          step_next   = STEP_A_BIT;
        end
      end
      STEP_A_BIT: begin
        if (a_bits == '0) begin
          step_next = STEP_A_FIN;
        end else begin
          if (a_bits[0]) begin
            plan_src = SRC_B;
            plan_len = HASH_BYTES;
          end else begin
            plan_len = plen_s;
          end
          a_bits_next = a_bits >> 1;
        end
      end
      STEP_A_FIN: begin
        plan_src  = SRC_PAD;
        plan_len  = SEG_W'(stat.pad_len);
        plan_fin  = 1'b1;
        plan_dst  = DST_A;
        rep_next  = REP_W'(stat.plen);
        step_next = STEP_DP_PW;
      end
      STEP_DP_PW: begin
        if (rep == '0) begin
          step_next = STEP_DP_FIN;
        end else begin
          plan_len = plen_s;
          rep_next = rep - REP_W'(1);
        end
      end
      STEP_DP_FIN: begin
        plan_src  = SRC_PAD;
        plan_len  = SEG_W'(stat.pad_len);
        plan_fin  = 1'b1;
        plan_dst  = DST_P;
        rep_next  = SALT_BASE_REPS + REP_W'(stat.a0);
        step_next = STEP_DS_SALT;
      end
      STEP_DS_SALT: begin
        if (rep == '0) begin
          step_next = STEP_DS_FIN;
        end else begin
          plan_src = SRC_SALT;
          plan_len = slen_s;
          rep_next = rep - REP_W'(1);
        end
      end
      STEP_DS_FIN: begin
        plan_src    = SRC_PAD;
        plan_len    = SEG_W'(stat.pad_len);
        plan_fin    = 1'b1;
        plan_dst    = DST_S;
        plan_rclear = 1'b1;
        step_next   = STEP_R_FIRST;
      end
      STEP_R_FIRST: begin
        if (stat.rounds_done) begin
          step_next = STEP_OUT;
        end else begin
          if (stat.r_odd) begin
            plan_src = SRC_PSEQ;
            plan_len = plen_s;
          end else begin
            plan_src = SRC_RUN;
            plan_len = HASH_BYTES;
          end
          step_next = STEP_R_SALT;
        end
      end
      STEP_R_SALT: begin
        plan_src  = SRC_SSEQ;
        plan_len  = stat.r3_zero ? '0 : slen_s;
        step_next = STEP_R_SEVEN;
      end
      STEP_R_SEVEN: begin
        plan_src  = SRC_PSEQ;
        plan_len  = stat.r7_zero ? '0 : plen_s;
        step_next = STEP_R_LAST;
      end
      STEP_R_LAST: begin
        if (stat.r_odd) begin
          plan_src = SRC_RUN;
          plan_len = HASH_BYTES;
        end else begin
          plan_src = SRC_PSEQ;
          plan_len = plen_s;
        end
        step_next = STEP_R_FIN;
      end
      STEP_R_FIN: begin
        plan_src  = SRC_PAD;
        plan_len  = SEG_W'(stat.pad_len);
        plan_fin  = 1'b1;
        plan_dst  = DST_RUN;
        plan_rinc = 1'b1;
        step_next = STEP_R_FIRST;
      end
      default: begin
        step_next = step;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (item.kind == KIND_COMPUTE)) begin
          state_next = ST_PLAN;
        end
      end
      ST_PLAN: begin
        if (step == STEP_OUT) begin
          state_next = ST_EMIT;
        end else if (plan_len != '0) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (stat.blk_last) begin
          state_next = ST_WAIT;
        end else if (seg_idx + SEG_W'(1) == seg_len) begin
          state_next = ST_PLAN;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_WAIT: begin
        if (stat.core_done) begin
          state_next = seg_done ? ST_PLAN : ST_READ;
        end
      end
      ST_EMIT: begin
        if (emit_idx == LAST_CHAR_IDX) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.load        = accept;
    cmd.msg_start   = accept && (item.kind == KIND_COMPUTE);
    cmd.shift       = (state == ST_SHIFT);
    cmd.src         = seg_src;
    cmd.idx         = seg_idx;
    cmd.pad_begin   = (state == ST_PLAN) && plan_fin;
    cmd.store       = (state == ST_WAIT) && stat.core_done && seg_done && (seg_src == SRC_PAD);
    cmd.dst         = seg_dst;
    cmd.round_clear = (state == ST_PLAN) && plan_rclear;
    cmd.round_inc   = (state == ST_PLAN) && plan_rinc;
    cmd.emit        = (state == ST_EMIT);
    cmd.emit_idx    = emit_idx;
    cmd.clear       = (state == ST_EMIT) && (emit_idx == LAST_CHAR_IDX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= STEP_B_PW1;
      seg_src  <= SRC_PW;
      seg_dst  <= DST_B;
      seg_len  <= '0;
      seg_idx  <= '0;
      a_rem    <= '0;
      a_bits   <= '0;
      rep      <= '0;
      emit_idx <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          step <= STEP_B_PW1;
        end
        ST_PLAN: begin
          step     <= step_next;
          a_rem    <= a_rem_next;
          a_bits   <= a_bits_next;
          rep      <= rep_next;
          seg_src  <= plan_src;
          seg_dst  <= plan_dst;
          seg_len  <= plan_len;
          seg_idx  <= '0;
          emit_idx <= '0;
        end
        ST_SHIFT: begin
          seg_idx <= seg_idx + SEG_W'(1);
        end
        ST_EMIT: begin
          emit_idx <= emit_idx + 6'd1;
        end
        default: begin
          seg_idx <= seg_idx;
        end
      endcase
    end
  end

endmodule

@@ src/sha256_crypt_password_hash_top.sv @@
// Top level of the SHA-256 crypt password hashing engine.
// A load word (password or salt byte) leaves busy low.
// A compute word keeps busy high while each message byte is read and shifted, each segment
// is planned and each 64-byte block runs through the shared one-round-per-cycle SHA-256
// unit, over all digests and round_count rounds; 43 characters then follow back to back.
// Synchronous active-high reset; round_count resets to 5000; results cannot be stalled.
module sha256_crypt_password_hash_top
  import shacrypt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Item channel: a word is taken when start is high and busy is low.
  input  logic        start,
  output logic        busy,
  input  in_word_t    item,
  // Result channel: each character word is valid for the single strobe cycle.
  output logic        strobe,
  output out_word_t   result,
  // Register port; register 0 is round_count at byte address 0.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ctrl_cmd_t          cmd;
  ctrl_stat_t         stat;
  logic [ROUND_W-1:0] round_count;
  logic [ROUND_W-1:0] wr_value;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && !paddr[2];
  assign wr_value  = pwdata[ROUND_W-1:0];

  // Out-of-range round counts are clamped into the legal range on write.
  always_ff @(posedge clk) begin
    if (rst) begin
      round_count <= ROUNDS_RESET;
    end else if (cfg_write) begin
      if (wr_value < ROUNDS_LOW) begin
        round_count <= ROUNDS_LOW;
      end else if (wr_value > ROUNDS_HIGH) begin
        round_count <= ROUNDS_HIGH;
      end else begin
        round_count <= wr_value;
      end
    end
  end

  // Only one register exists; the other word address reads as zero.
  assign prdata = paddr[2] ? 32'd0 : {2'b00, round_count};

  shacrypt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  shacrypt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cmd         (cmd),
    .round_count (round_count),
    .stat        (stat),
    .strobe      (strobe),
    .result      (result)
  );

endmodule

@@ tb/sha256_crypt_password_hash_checker.sv @@
// Checker for the SHA-256 crypt engine: predicts each digest and compares the characters.
`timescale 1ns / 1ps

module sha256_crypt_password_hash_checker
  import shacrypt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  in_word_t    item,
  input  logic        strobe,
  input  out_word_t   result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          errors,
  output int          pending,
  output int          chars_checked
);

  typedef logic [7:0] digest_t [32];
  typedef logic [7:0] bytes_t [$];

  localparam logic [2:0] ADDR_ROUND_COUNT = 3'd0;
  localparam string CRYPT_ALPHABET =
    "./0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam int GROUP_POS [10][3] = '{
    '{0, 10, 20}, '{21, 1, 11}, '{12, 22, 2}, '{3, 13, 23}, '{24, 4, 14},
    '{15, 25, 5}, '{6, 16, 26}, '{27, 7, 17}, '{18, 28, 8}, '{9, 19, 29}
  };

  logic [29:0] rounds;
  logic [7:0]  pw_bytes [MAX_PASSWORD_BYTES];
  logic [7:0]  salt_bytes [MAX_SALT_BYTES];
  int          pw_len, salt_cnt;
  logic        dropped;
  out_word_t   digest_chars [$];

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic digest_t sha256(bytes_t m);
    logic [31:0] h [8];
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    logic [63:0] bits;
    digest_t     d;
    bits = 64'(m.size()) * 8;
    m.push_back(8'h80);
    while (m.size() % 64 != 56) m.push_back(8'h00);
    for (int i = 0; i < 8; i++) m.push_back(bits[63 - 8 * i -: 8]);
    h = SHA_IV;
    for (int b = 0; b < m.size(); b += 64) begin
      for (int i = 0; i < 16; i++)
        w[i] = {m[b + 4 * i], m[b + 4 * i + 1], m[b + 4 * i + 2], m[b + 4 * i + 3]};
      for (int i = 16; i < 64; i++)
        w[i] = w[i - 16] + w[i - 7]
             + (ror32(w[i - 15], 7) ^ ror32(w[i - 15], 18) ^ (w[i - 15] >> 3))
             + (ror32(w[i - 2], 17) ^ ror32(w[i - 2], 19) ^ (w[i - 2] >> 10));
      v = h;
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
        t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) h[i] += v[i];
    end
    for (int i = 0; i < 32; i++) d[i] = h[i / 4][31 - 8 * (i % 4) -: 8];
    return d;
  endfunction

  // Runs the full crypt scheme over the stores and queues the 43 characters.
  function automatic void predict_hash();
    bytes_t      m;
    digest_t     db, da, dp, ds, run;
    logic [7:0]  pseq [MAX_PASSWORD_BYTES];
    logic [7:0]  sseq [MAX_SALT_BYTES];
    logic [23:0] grp;
    out_word_t   c;
    int          n;

    m = {};
    for (int i = 0; i < pw_len; i++) m.push_back(pw_bytes[i]);
    for (int i = 0; i < salt_cnt; i++) m.push_back(salt_bytes[i]);
    for (int i = 0; i < pw_len; i++) m.push_back(pw_bytes[i]);
    db = sha256(m);

    m = {};
    for (int i = 0; i < pw_len; i++) m.push_back(pw_bytes[i]);
    for (int i = 0; i < salt_cnt; i++) m.push_back(salt_bytes[i]);
    for (int i = 0; i < pw_len; i++) m.push_back(db[i % 32]);
    for (int k = pw_len; k > 0; k >>= 1) begin
      if (k & 1) begin
        for (int i = 0; i < 32; i++) m.push_back(db[i]);
      end else begin
        for (int i = 0; i < pw_len; i++) m.push_back(pw_bytes[i]);
      end
    end
    da = sha256(m);

    m = {};
    for (int j = 0; j < pw_len; j++)
      for (int i = 0; i < pw_len; i++) m.push_back(pw_bytes[i]);
    dp = sha256(m);
    for (int i = 0; i < pw_len; i++) pseq[i] = dp[i % 32];

    m = {};
    for (int j = 0; j < 16 + da[0]; j++)
      for (int i = 0; i < salt_cnt; i++) m.push_back(salt_bytes[i]);
    ds = sha256(m);
    for (int i = 0; i < salt_cnt; i++) sseq[i] = ds[i % 32];

    run = da;
    for (int r = 0; r < rounds; r++) begin
      m = {};
      if (r % 2) begin
        for (int i = 0; i < pw_len; i++) m.push_back(pseq[i]);
      end else begin
        for (int i = 0; i < 32; i++) m.push_back(run[i]);
      end
      if (r % 3) for (int i = 0; i < salt_cnt; i++) m.push_back(sseq[i]);
      if (r % 7) for (int i = 0; i < pw_len; i++) m.push_back(pseq[i]);
      if (r % 2) begin
        for (int i = 0; i < 32; i++) m.push_back(run[i]);
      end else begin
        for (int i = 0; i < pw_len; i++) m.push_back(pseq[i]);
      end
      run = sha256(m);
    end

    for (int g = 0; g < 11; g++) begin
      if (g < 10) begin
        grp = {run[GROUP_POS[g][0]], run[GROUP_POS[g][1]], run[GROUP_POS[g][2]]};
      end else begin
        grp = {8'h00, run[31], run[30]};
      end
      n = (g < 10) ? 4 : 3;
      for (int k = 0; k < n; k++) begin
        c.out_char        = CRYPT_ALPHABET[grp[5:0]];
        c.last_char       = (g == 10 && k == 2);
        c.input_truncated = dropped;
        digest_chars.push_back(c);
        grp = grp >> 6;
      end
    end
  endfunction

  function automatic void report(string what, logic [31:0] exp_v, logic [31:0] got_v);
    errors++;
    if (errors <= 10)
      $display("MISMATCH %s: expected %h, got %h", what, exp_v, got_v);
  endfunction

  assign pending = digest_chars.size();

  always @(posedge clk) begin
    out_word_t e;
    logic [29:0] v;
    if (rst) begin
      rounds   <= ROUNDS_RESET;
      pw_len   = 0;
      salt_cnt = 0;
      dropped  = 1'b0;
    end else begin
      if (psel && penable && pready && paddr == ADDR_ROUND_COUNT) begin
        if (pwrite) begin
          v = pwdata[29:0];
          if (v < ROUNDS_LOW) v = ROUNDS_LOW;
          if (v > ROUNDS_HIGH) v = ROUNDS_HIGH;
          rounds <= v;
        end else if (prdata != {2'b00, rounds}) begin
          report("round_count readback", {2'b00, rounds}, prdata);
        end
      end
      if (start && !busy) begin
        case (item.kind)
          KIND_PW: begin
            if (pw_len < MAX_PASSWORD_BYTES) begin
              pw_bytes[pw_len] = item.data_byte;
              pw_len = pw_len + 1;
            end else begin
              dropped = 1'b1;
            end
          end
          KIND_SALT: begin
            if (salt_cnt < MAX_SALT_BYTES) begin
              salt_bytes[salt_cnt] = item.data_byte;
              salt_cnt = salt_cnt + 1;
            end else begin
              dropped = 1'b1;
            end
          end
          KIND_COMPUTE: begin
            predict_hash();
            pw_len   = 0;
            salt_cnt = 0;
            dropped  = 1'b0;
          end
          default: ;
        endcase
      end
      if (strobe) begin
        if (digest_chars.size() == 0) begin
          report("unexpected character", 32'h0, {22'h0, result});
        end else begin
          e = digest_chars.pop_front();
          chars_checked++;
          if (result.out_char != e.out_char)
            report("out_char", e.out_char, result.out_char);
          if (result.last_char != e.last_char)
            report("last_char", e.last_char, result.last_char);
          if (result.input_truncated != e.input_truncated)
            report("input_truncated", e.input_truncated, result.input_truncated);
        end
      end
    end
  end

  initial begin
    errors        = 0;
    chars_checked = 0;
  end

endmodule

@@ tb/tb.sv @@
// Testbench top: drives password, salt and compute words into the SHA-256 crypt engine.
`timescale 1ns / 1ps

module tb;
  import shacrypt_pkg::*;

  // The unused fourth kind code is only sent as noise that the block must ignore.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_ROUND_COUNT = 3'd0;
  // A compute with a full 64-byte password at up to 1003 rounds is the slowest silent
  // stretch; the limit is set above it.
  localparam int STALL_LIMIT = 4000000;

  logic        clk, rst;
  logic        start, busy, strobe;
  in_word_t    item;
  out_word_t   result;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          errors, pending, chars_checked;
  int          words_sent, hashes_sent, burst_left, quiet_cycles;

  sha256_crypt_password_hash_top dut (
    .clk, .rst, .start, .busy, .item, .strobe, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sha256_crypt_password_hash_checker checker_i (
    .clk, .rst, .start, .busy, .item, .strobe, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .errors, .pending, .chars_checked
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog restarts on any accepted word, character or register access.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Sends one word. The sender works in bursts: when a burst is used up, start
  // drops for a random gap. busy is sampled at the falling edge, where it is stable,
  // so the word is accepted at the following rising edge.
  task automatic send_word(logic [1:0] kind, logic [7:0] data);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start          <= 1'b1;
    item.kind      <= kind;
    item.data_byte <= data;
    do @(negedge clk); while (busy);
    @(posedge clk);
    words_sent++;
    if (kind == KIND_COMPUTE) hashes_sent++;
  endtask

  // Holds the sender off until every predicted character has come out, then lets
  // the block settle so a register access finds it idle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_access(logic wr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_ROUND_COUNT;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes round_count and reads it back; the checker compares the read value.
  task automatic set_rounds(logic [31:0] value);
    reg_access(1'b1, value);
    reg_access(1'b0, 32'h0);
  endtask

  initial begin
    int npw, nsalt;
    rst        = 1'b1;
    start      = 1'b0;
    item       = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    words_sent   = 0;
    hashes_sent  = 0;
    burst_left   = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register extremes: the reset value, an all-ones write that clamps to the
    // top of the range, the top itself, and a zero write that clamps to the floor.
    reg_access(1'b0, 32'h0);
    set_rounds(32'hffff_ffff);
    set_rounds(32'd999999999);
    set_rounds(32'd0);

    // Empty password and salt at the minimum round count.
    send_word(KIND_COMPUTE, 8'h00);
    drain();

    // Extreme byte values, ignored unused-kind noise, and a salt store that
    // overflows so the truncation flag shows on every character.
    set_rounds(32'd999);
    send_word(KIND_PW, 8'h00);
    send_word(KIND_PW, 8'hff);
    send_word(KIND_UNUSED, 8'hff);
    for (int i = 0; i < MAX_SALT_BYTES + 1; i++) send_word(KIND_SALT, i[0] ? 8'hff : 8'h00);
    send_word(KIND_UNUSED, 8'h00);
    send_word(KIND_COMPUTE, 8'hff);
    drain();

    // Random phase. The first sequence fills the password store past its end;
    // the rest use short passwords so each hash stays affordable.
    for (int s = 0; s < 3; s++) begin
      set_rounds($urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 999))
                                           : 32'($urandom_range(1000, 1003)));
      npw   = (s == 0) ? MAX_PASSWORD_BYTES + $urandom_range(1, 3) : $urandom_range(0, 10);
      nsalt = (s == 0) ? $urandom_range(0, 3) : $urandom_range(0, MAX_SALT_BYTES + 2);
      while (npw + nsalt > 0) begin
        if ($urandom_range(0, 15) == 0) begin
          send_word(KIND_UNUSED, 8'($urandom));
        end else if (nsalt > 0 && (npw == 0 || $urandom_range(0, 1))) begin
          send_word(KIND_SALT, 8'($urandom));
          nsalt--;
        end else begin
          send_word(KIND_PW, 8'($urandom));
          npw--;
        end
      end
      send_word(KIND_COMPUTE, 8'($urandom));
      drain();
    end

    repeat (50) @(posedge clk);
    $display("Sent %0d words including %0d hash computes; %0d digest characters checked.",
             words_sent, hashes_sent, chars_checked);
    $display("Covered empty, overflowing and random stores and clamped round counts.");
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
